/* sv/cdr_pkg.sv */
// Shared constants and types for the circular deque with restricted modes.
package cdr_pkg;

    // Ring size and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    // Field widths of the transactions.
    localparam int OP_W     = 3;
    localparam int OFFSET_W = 4;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;

    // Operation codes; codes above OP_READ are refused.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // Restriction modes; the unused code behaves as unrestricted.
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUTPUT = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DISALLOWED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

/* sv/circular_deque_restricted_top.sv */
// Top level of the circular deque: request decode, pointer state, ring RAM and result register.
//
// The block keeps a double-ended queue of up to DEPTH signed 32-bit words in a
// ring RAM. Each request transaction on the s_ channel pushes at the front or
// rear, pops from the front or rear, or reads the word at an offset from the
// front. Every request yields exactly one result transaction on the m_ channel
// carrying a status, the popped or read word (zero otherwise), the element
// count and the empty and full flags after the request.
// A push or a refused request has its result registered at the acceptance edge.
// A successful pop or read goes through the ST_READ state, since the word comes
// from the RAM's registered read port and is then registered in the result.
// No new request is taken while a pop or read is still fetching its word.
// The cfg_we/cfg_wdata port sets the restriction mode; the user must write it only
// while the block is idle, since the block itself does not enforce this.
// Reset (aresetn low at a rising edge) empties the deque, clears the mode to
// unrestricted and drops m_tvalid. The RAM contents are not cleared; only slots
// that hold elements are ever read.
// When the receiver stalls, the result stays in the output register and
// s_tready falls until that result is taken or taken in the same cycle.
module circular_deque_restricted_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: restriction mode.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,

    // Requests. tdata: operation[2:0], value[34:3], offset[38:35], zero[39].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,

    // Results. tdata: status[2:0], data_out[34:3], count[39:35], is_empty[40],
    // is_full[41], zero[47:42].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int IDX_W  = cdr_pkg::IDX_W;
    localparam int CNT_W  = cdr_pkg::CNT_W;
    localparam int WORD_W = cdr_pkg::WORD_W;

    // Unpacked request fields.
    logic [cdr_pkg::OP_W-1:0]     op;
    logic signed [WORD_W-1:0]     value;
    logic [cdr_pkg::OFFSET_W-1:0] offset;

    assign op     = s_tdata[2:0];
    assign value  = s_tdata[34:3];
    assign offset = s_tdata[38:35];

    // Control state.
    cdr_pkg::state_t                state_reg, state_next;
    logic [IDX_W-1:0]               head_reg, head_next;
    logic [IDX_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]               occ_reg, occ_next;
    logic [cdr_pkg::MODE_W-1:0]     mode_reg, mode_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // Result payload.
    logic [cdr_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic signed [WORD_W-1:0]       data_reg, data_next;
    logic [CNT_W-1:0]               count_reg, count_next;

    // Decode results for the request at the inputs.
    logic [cdr_pkg::STATUS_W-1:0]   req_status;
    logic [IDX_W-1:0]               req_head, req_tail;
    logic [CNT_W-1:0]               req_occ;
    logic                           req_write, req_read;
    logic [IDX_W-1:0]               req_waddr, req_raddr;

    logic                           accept;
    logic                           disallowed;
    logic signed [WORD_W-1:0]       ram_rdata;

    // RAM port signals.
    logic                           ram_we, ram_re;

    assign disallowed = (op > cdr_pkg::OP_READ) ||
                        (op == cdr_pkg::OP_PUSH_FRONT && mode_reg == cdr_pkg::MODE_INPUT) ||
                        (op == cdr_pkg::OP_POP_REAR && mode_reg == cdr_pkg::MODE_OUTPUT);

    // Request decode: status, new pointers and the RAM access it needs.
    always_comb begin
        req_status = cdr_pkg::STAT_OK;
        req_head   = head_reg;
        req_tail   = tail_reg;
        req_occ    = occ_reg;
        req_write  = 1'b0;
        req_read   = 1'b0;
        req_waddr  = tail_reg;
        req_raddr  = head_reg;

        priority if (disallowed) begin
            req_status = cdr_pkg::STAT_DISALLOWED;
        end else if (op == cdr_pkg::OP_PUSH_FRONT || op == cdr_pkg::OP_PUSH_REAR) begin
            if (occ_reg == CNT_W'(cdr_pkg::DEPTH)) begin
                req_status = cdr_pkg::STAT_OVERFLOW;
            end else begin
                req_write = 1'b1;
                req_occ   = occ_reg + CNT_W'(1);
                priority if (occ_reg == '0) begin
                    // First element lands in slot zero from either end.
                    req_head  = '0;
                    req_tail  = '0;
                    req_waddr = '0;
                end else if (op == cdr_pkg::OP_PUSH_FRONT) begin
                    req_head  = head_reg - IDX_W'(1);
                    req_waddr = head_reg - IDX_W'(1);
                end else begin
                    req_tail  = tail_reg + IDX_W'(1);
                    req_waddr = tail_reg + IDX_W'(1);
                end
            end
        end else if (op == cdr_pkg::OP_POP_FRONT || op == cdr_pkg::OP_POP_REAR) begin
            if (occ_reg == '0) begin
                req_status = cdr_pkg::STAT_UNDERFLOW;
            end else begin
                req_read = 1'b1;
                req_occ  = occ_reg - CNT_W'(1);
                if (op == cdr_pkg::OP_POP_FRONT) begin
                    req_raddr = head_reg;
                    // Popping the last element leaves the pointers where they are.
                    if (occ_reg != CNT_W'(1)) begin
                        req_head = head_reg + IDX_W'(1);
                    end
                end else begin
                    req_raddr = tail_reg;
                    if (occ_reg != CNT_W'(1)) begin
                        req_tail = tail_reg - IDX_W'(1);
                    end
                end
            end
        end else begin
            if (CNT_W'(offset) >= occ_reg) begin
                req_status = cdr_pkg::STAT_RANGE;
            end else begin
                req_read  = 1'b1;
                req_raddr = head_reg + IDX_W'(offset);
            end
        end
    end

    // A request is taken only in idle and only when the result register is
    // free or being emptied in this cycle.
    assign s_tready = (state_reg == cdr_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);

    // Sequencer and next-state logic.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        mode_next     = cfg_we ? cfg_wdata : mode_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        data_next     = data_reg;
        count_next    = count_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            cdr_pkg::ST_IDLE: begin
                if (accept) begin
                    head_next   = req_head;
                    tail_next   = req_tail;
                    occ_next    = req_occ;
                    status_next = req_status;
                    count_next  = req_occ;
                    data_next   = '0;
                    ram_we      = req_write;
                    ram_re      = req_read;
                    if (req_read) begin
                        // The word arrives from the RAM next cycle.
                        m_tvalid_next = 1'b0;
                        state_next    = cdr_pkg::ST_READ;
                    end else begin
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            cdr_pkg::ST_READ: begin
                data_next     = ram_rdata;
                m_tvalid_next = 1'b1;
                state_next    = cdr_pkg::ST_IDLE;
            end
            default: begin
                state_next = cdr_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cdr_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            mode_reg     <= cdr_pkg::MODE_FREE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
    end

    // Ring store.
    cdr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (cdr_pkg::DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (req_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (req_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0,
                       count_reg == CNT_W'(cdr_pkg::DEPTH),
                       count_reg == '0,
                       count_reg,
                       data_reg,
                       status_reg};

endmodule

/* sv/cdr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module cdr_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* verif/tb_circular_deque_restricted_top.sv */
// Self-checking testbench for the circular deque with restriction modes.
module tb_circular_deque_restricted_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdr_pkg::*;

    // The package names three restriction modes. The fourth code is unused and
    // must behave as unrestricted, so the bench gives it a name of its own.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 4;     // quiet cycles before a mode write
    localparam int DRAIN_CYCLES    = 10;    // quiet cycles before the verdict
    localparam int HOLD_OFF_CYCLES = 48;    // long receiver stall that fills the block
    localparam int PHASED_ITEMS    = 1600;  // random items spread over mode phases
    localparam int FINAL_ITEMS     = 150;   // closing stretch with no idling at all
    localparam int WATCHDOG_NS     = 1_000_000;

    // One result transaction, unpacked into its fields.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic [CNT_W-1:0]    count;
        logic                is_empty;
        logic                is_full;
    } deque_reply_t;

    // Random phases lean toward filling, draining or a balance of both.
    typedef enum int {
        FLAVOR_FILL,
        FLAVOR_DRAIN,
        FLAVOR_MIXED
    } phase_flavor_t;

    // Shadow copy of the deque. Every accepted request is applied here and the
    // reply it must produce is queued; every accepted result is compared with
    // the oldest queued reply.
    class deque_mirror;
        logic [WORD_W-1:0] ring [DEPTH];
        logic [IDX_W-1:0]  head;
        logic [IDX_W-1:0]  tail;
        logic [CNT_W-1:0]  occupied;
        logic [MODE_W-1:0] mode;
        deque_reply_t      pending_replies[$];
        int                mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            head       = '0;
            tail       = '0;
            occupied   = '0;
            mode       = MODE_FREE;
            mismatches = 0;
        endfunction

        // Applies one accepted request to the shadow deque and queues its reply.
        function void note_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                                   logic [OFFSET_W-1:0] offset);
            deque_reply_t     reply;
            logic [IDX_W-1:0] slot;
            reply        = '0;
            reply.status = STAT_OK;
            // The mode check wins over overflow and underflow.
            if (op > OP_READ || (op == OP_PUSH_FRONT && mode == MODE_INPUT) ||
                (op == OP_POP_REAR && mode == MODE_OUTPUT)) begin
                reply.status = STAT_DISALLOWED;
            end else if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
                if (occupied == CNT_W'(DEPTH)) begin
                    reply.status = STAT_OVERFLOW;
                end else begin
                    // A push into an empty deque restarts both indices at slot 0.
                    if (occupied == '0) begin
                        head = '0;
                        tail = '0;
                    end else if (op == OP_PUSH_FRONT) begin
                        head = head - 1'b1;
                    end else begin
                        tail = tail + 1'b1;
                    end
                    ring[(op == OP_PUSH_FRONT) ? head : tail] = value;
                    occupied++;
                end
            end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
                // Popping the last element leaves the indices where they are.
                if (occupied == '0) begin
                    reply.status = STAT_UNDERFLOW;
                end else if (op == OP_POP_FRONT) begin
                    reply.data = ring[head];
                    occupied--;
                    if (occupied != '0) head = head + 1'b1;
                end else begin
                    reply.data = ring[tail];
                    occupied--;
                    if (occupied != '0) tail = tail - 1'b1;
                end
            end else if (offset >= occupied) begin
                reply.status = STAT_RANGE;
            end else begin
                slot       = head + offset;
                reply.data = ring[slot];
            end
            reply.count    = occupied;
            reply.is_empty = (occupied == '0);
            reply.is_full  = (occupied == CNT_W'(DEPTH));
            pending_replies.push_back(reply);
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Checks one accepted result transaction against the oldest reply.
        function void check_result(logic [47:0] word);
            deque_reply_t want;
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", WORD_W'(want.status), WORD_W'(word[2:0]));
            compare_field("data_out", want.data, word[34:3]);
            compare_field("count", WORD_W'(want.count), WORD_W'(word[39:35]));
            compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(word[40]));
            compare_field("is_full", WORD_W'(want.is_full), WORD_W'(word[41]));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // operation, value, offset, zero pad (lowest bit up)
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // status, data_out, count, is_empty, is_full, zero pad

    deque_mirror mirror = new();

    // Random idling is allowed on both sides while this is set.
    bit idle_on = 1'b1;
    // Raised by the request driver and cleared by the receiver once its long
    // stall is over.
    bit hold_off_req = 1'b0;

    circular_deque_restricted_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Leaves the request channel idle for the given number of cycles. The data
    // lines carry junk meanwhile so that nothing depends on them.
    task automatic sender_gap(input int cycles);
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tdata  = 40'({$urandom(), $urandom()});
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Offers one request transaction and holds it until the block takes it.
    // Inputs change at the falling edge; the handshake is sampled at the rising
    // edge, where the shadow deque is updated. Valid stays high into the next
    // offer unless a gap follows.
    task automatic offer(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                         input logic [OFFSET_W-1:0] offset);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, offset, value, op};
        do @(posedge aclk); while (!s_tready);
        mirror.note_request(op, value, offset);
        if (idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 11));
    endtask

    // Writes the restriction mode. The block must be idle, so the request
    // channel is lowered and every queued reply has to arrive first.
    task automatic set_restriction(input logic [MODE_W-1:0] mode);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mirror.pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge aclk);
        cfg_we    = 1'b0;
        mirror.mode = mode;
    endtask

    // Draws one random request. Reads aim inside the stored range half of the
    // time, and a few unknown operation codes are mixed in as noise.
    task automatic random_request(input phase_flavor_t flavor);
        int                  roll;
        int                  push_share;
        logic [OP_W-1:0]     op;
        logic [OFFSET_W-1:0] offset;
        case (flavor)
            FLAVOR_FILL:  push_share = 80;
            FLAVOR_DRAIN: push_share = 20;
            default:      push_share = 50;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            op = OP_W'($urandom_range(OP_READ + 1, (1 << OP_W) - 1));
        end else if (roll < 20) begin
            op = OP_READ;
        end else if ($urandom_range(0, 99) < push_share) begin
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        end else begin
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
        end
        if (mirror.occupied == '0 || $urandom_range(0, 1) == 0) begin
            offset = OFFSET_W'($urandom());
        end else begin
            offset = OFFSET_W'($urandom_range(0, mirror.occupied - 1));
        end
        offer(op, $urandom(), offset);
    endtask

    // Hand-picked opening sequence: underflow on both ends, a read of an empty
    // deque, every unknown operation code, pushes of the word extremes on both
    // ends, reads in range and past the end, then the refused request of each
    // restricted mode and the spare mode acting as unrestricted. It ends by
    // popping the last element, so the random part starts from an empty
    // deque.
    task automatic run_directed();
        offer(OP_POP_FRONT, '0, '0);
        offer(OP_POP_REAR, '0, '0);
        offer(OP_READ, '0, '0);
        for (int code = OP_READ + 1; code < (1 << OP_W); code++) begin
            offer(OP_W'(code), '1, '1);
        end
        offer(OP_PUSH_FRONT, 32'h8000_0000, '0);
        offer(OP_PUSH_REAR, 32'h7fff_ffff, '0);
        offer(OP_PUSH_FRONT, 32'hffff_ffff, '0);
        offer(OP_PUSH_REAR, 32'h0000_0000, '1);
        offer(OP_READ, '0, 4'd0);
        offer(OP_READ, '0, 4'd3);
        offer(OP_READ, '0, 4'd4);
        offer(OP_READ, '1, 4'd15);
        offer(OP_POP_FRONT, '0, '0);
        offer(OP_POP_REAR, '0, '0);
        set_restriction(MODE_INPUT);
        offer(OP_PUSH_FRONT, 32'h1234_5678, '0);
        offer(OP_PUSH_REAR, 32'h5a5a_5a5a, '0);
        set_restriction(MODE_OUTPUT);
        offer(OP_POP_REAR, '0, '0);
        offer(OP_POP_FRONT, '0, '0);
        set_restriction(MODE_SPARE);
        offer(OP_PUSH_FRONT, 32'ha5a5_a5a5, '0);
        offer(OP_POP_REAR, '0, '0);
        offer(OP_POP_FRONT, '0, '0);
        offer(OP_POP_FRONT, '0, '0);
    endtask

    // Request side: reset, directed part, random phases, a closing stretch
    // with no idling, then the verdict.
    initial begin
        int               phase;
        int               sent;
        int               length;
        phase_flavor_t    flavor;
        logic [MODE_W-1:0] mode;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_restriction(MODE_FREE);
        run_directed();

        // Each phase runs under one mode. The first four phases go through all
        // mode codes, later ones pick at random. Two phases start with a long
        // receiver stall while requests keep coming without gaps, which fills
        // the result path and pushes back on the request channel.
        phase = 0;
        sent  = 0;
        while (sent < PHASED_ITEMS) begin
            case (phase)
                0:       mode = MODE_OUTPUT;
                1:       mode = MODE_FREE;
                2:       mode = MODE_SPARE;
                3:       mode = MODE_INPUT;
                default: mode = MODE_W'($urandom_range(0, 3));
            endcase
            set_restriction(mode);
            flavor  = phase_flavor_t'($urandom_range(0, 2));
            length  = $urandom_range(60, 140);
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 6) begin
                idle_on      = 1'b0;
                hold_off_req = 1'b1;
            end
            repeat (length) random_request(flavor);
            sent  += length;
            phase += 1;
        end

        // Closing stretch at full rate on both sides.
        set_restriction(MODE_W'($urandom_range(0, 3)));
        idle_on = 1'b0;
        repeat (FINAL_ITEMS) random_request(FLAVOR_MIXED);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mirror.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: ready changes at the falling edge. It stalls in random
    // bursts while idling is allowed, and once per request for a long count.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Every result transaction is checked at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.check_result(m_tdata);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
